/* rtl/counted_resource_grant_manager_top_macros.svh */
// Assertion macros for the checker file.
`ifndef COUNTED_RESOURCE_GRANT_MANAGER_TOP_MACROS_SVH
`define COUNTED_RESOURCE_GRANT_MANAGER_TOP_MACROS_SVH

// Check a property outside reset.
`define CRGM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("crgm assertion failed");

// Check a property at every edge, reset included.
`define CRGM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("crgm assertion failed");

`endif

/* rtl/crgm_pkg.sv */
// ----------------------------------------------------------------------------
// crgm_pkg
// Shared constants, codes and types of the counted resource grant manager.
// ----------------------------------------------------------------------------
package crgm_pkg;

  localparam int NUM_BOXES   = 8;
  localparam int MAX_CLIENTS = 16;
  localparam int MAX_HELD    = 32;
  localparam int POS_SCALE   = 100;

  localparam int BOX_SLOTS  = 8;  // fixed by the packed 8 x 8-bit registers
  localparam int SLOT_W     = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int HIDX_W     = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int HLEN_W     = $clog2(MAX_HELD + 1);
  localparam int WQ_LEN_W   = $clog2(MAX_CLIENTS + 1);
  localparam int HMEM_DEPTH = MAX_CLIENTS * MAX_HELD;
  localparam int HADDR_W    = $clog2(HMEM_DEPTH);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XPOS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_YPOS   = 2'd2;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_MOVE    = 3'd1,
    OP_REQUEST = 3'd2,
    OP_KILL    = 3'd3,
    OP_LOCATE  = 3'd4,
    OP_NOP     = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BLOCKED = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_EXISTS  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] client_id;
    logic [2:0] res;
  } item_t;

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [7:0]  woken_client;
    logic [2:0]  granted_resource;
    logic [14:0] location;
    logic        last;
  } result_t;

  // Fold a box index into range by repeated subtraction.
  function automatic logic [2:0] box_wrap(input logic [2:0] r);
    logic [3:0] v;
    v = {1'b0, r};
    for (int k = 0; k < 8; k++) begin
      if (v >= 4'(NUM_BOXES)) v = v - 4'(NUM_BOXES);
    end
    return v[2:0];
  endfunction

endpackage

/* rtl/crgm_ifs.sv */
// ----------------------------------------------------------------------------
// crgm_req_if / crgm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface crgm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] client_id;
  logic [2:0] resource;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  modport source (output valid, operation, client_id, resource, pos_x, pos_y,
                  input ready);
  modport sink (input valid, operation, client_id, resource, pos_x, pos_y,
                output ready);
endinterface

interface crgm_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [7:0]  woken_client;
  logic [2:0]  granted_resource;
  logic [14:0] location;
  logic        last;
  modport source (output valid, kind, status, woken_client, granted_resource,
                  location, last, input ready);
  modport sink (input valid, kind, status, woken_client, granted_resource,
                location, last, output ready);
endinterface

/* rtl/crgm_front.sv */
// ----------------------------------------------------------------------------
// crgm_front
// Accept requests, decode the operation, wrap the box index, queue two deep.
// ----------------------------------------------------------------------------
module crgm_front (
  input  logic             clk,
  input  logic             rst,
  crgm_req_if.sink         req,
  output crgm_pkg::item_t  item,
  output logic             item_valid,
  input  logic             item_ready
);
  import crgm_pkg::*;

  item_t      q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;
  item_t      dec;

  always_comb begin
    dec.client_id = req.client_id;
    dec.res       = box_wrap(req.resource);
    unique case (req.operation)
      3'd0:    dec.op = OP_CREATE;
      3'd1:    dec.op = OP_MOVE;
      3'd2:    dec.op = OP_REQUEST;
      3'd3:    dec.op = OP_KILL;
      3'd4:    dec.op = OP_LOCATE;
      default: dec.op = OP_NOP;
    endcase
  end

  assign req.ready  = (cnt != 2'd2);
  assign push       = req.valid & req.ready;
  assign item_valid = (cnt != 2'd0);
  assign pop        = item_valid & item_ready;
  assign item       = q[rp];

  always_ff @(posedge clk) begin
    if (push) q[wp] <= dec;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

/* rtl/crgm_exec.sv */
// ----------------------------------------------------------------------------
// crgm_exec
// Carry out one request at a time against the client, box and queue state.
// ----------------------------------------------------------------------------
module crgm_exec (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [crgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  crgm_pkg::item_t                item,
  input  logic                           item_valid,
  output logic                           item_ready,
  output crgm_pkg::result_t              res,
  output logic                           res_valid,
  input  logic                           res_ready
);
  import crgm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_KILL_RD, S_KILL_PROC, S_EMIT} state_t;

  state_t              state;
  logic [7:0]          box_count [BOX_SLOTS];
  logic [63:0]         box_x, box_y;
  logic                slot_valid [MAX_CLIENTS];
  logic [7:0]          slot_client [MAX_CLIENTS];
  logic [HLEN_W-1:0]   held_len [MAX_CLIENTS];
  logic [SLOT_W-1:0]   wq_slot [MAX_CLIENTS];
  logic [2:0]          wq_res [MAX_CLIENTS];
  logic [WQ_LEN_W-1:0] wq_len;
  logic [2:0]          hmem [HMEM_DEPTH];
  logic [2:0]          hrdata;
  logic [SLOT_W-1:0]   kslot;
  logic [HLEN_W-1:0]   kidx, klen;

  // decode helpers
  logic              s_found, free_found, in_q, w_found;
  logic [SLOT_W-1:0] s_idx, free_idx, w_slot, hl_addr;
  logic [SLOT_W-1:0] q_pos, w_pos, rm_pos;
  logic [HLEN_W-1:0] hl_rd;
  logic [2:0]        bc_addr;
  logic [7:0]        bc_rd;
  logic              busy_idle, req_grant, req_wait, kill_go, wake, wake_app;
  logic              rm_en, hm_we, hm_re;
  logic [HADDR_W-1:0] hm_waddr, hm_raddr;
  logic [2:0]        hm_wdata;
  logic [14:0]       loc;

  always_comb begin
    s_found = 1'b0; s_idx = '0; free_found = 1'b0; free_idx = '0;
    for (int i = MAX_CLIENTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_client[i] == item.client_id) begin
        s_found = 1'b1;
        s_idx   = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
    in_q = 1'b0; q_pos = '0; w_found = 1'b0; w_pos = '0;
    for (int k = MAX_CLIENTS - 1; k >= 0; k--) begin
      if (WQ_LEN_W'(k) < wq_len && wq_slot[k] == s_idx) begin
        in_q  = 1'b1;
        q_pos = SLOT_W'(k);
      end
      if (WQ_LEN_W'(k) < wq_len && wq_res[k] == hrdata) begin
        w_found = 1'b1;
        w_pos   = SLOT_W'(k);
      end
    end
  end

  assign w_slot  = wq_slot[w_pos];
  assign hl_addr = (state == S_KILL_PROC) ? w_slot : s_idx;
  assign hl_rd   = held_len[hl_addr];
  assign bc_addr = (state == S_KILL_PROC) ? hrdata : item.res;
  assign bc_rd   = box_count[bc_addr];

  assign busy_idle = (state == S_IDLE) && item_valid;
  assign req_grant = busy_idle && item.op == OP_REQUEST && s_found && !in_q &&
                     hl_rd < HLEN_W'(MAX_HELD) && bc_rd != 8'd0;
  assign req_wait  = busy_idle && item.op == OP_REQUEST && s_found && !in_q &&
                     hl_rd < HLEN_W'(MAX_HELD) && bc_rd == 8'd0 &&
                     wq_len < WQ_LEN_W'(MAX_CLIENTS);
  assign kill_go   = busy_idle && item.op == OP_KILL && s_found;
  assign wake      = (state == S_KILL_PROC) && w_found;
  assign wake_app  = wake && hl_rd < HLEN_W'(MAX_HELD);
  assign rm_en     = (kill_go && in_q) || wake;
  assign rm_pos    = wake ? w_pos : q_pos;

  assign hm_we    = req_grant || wake_app;
  assign hm_waddr = HADDR_W'(hl_addr) * HADDR_W'(MAX_HELD) + HADDR_W'(hl_rd);
  assign hm_wdata = wake ? hrdata : item.res;
  assign hm_re    = (state == S_KILL_RD) && kidx != klen;
  assign hm_raddr = HADDR_W'(kslot) * HADDR_W'(MAX_HELD) + HADDR_W'(kidx);

  assign loc = 15'(box_x[8*item.res +: 8]) * 15'(POS_SCALE)
             + 15'(box_y[8*item.res +: 8]);

  assign res_valid  = (state == S_EMIT);
  assign item_ready = res_valid && res_ready && res.last;

  always_ff @(posedge clk) begin
    if (hm_we) hmem[hm_waddr] <= hm_wdata;
    if (hm_re) hrdata <= hmem[hm_raddr];
  end

  always_ff @(posedge clk) begin
    // wait queue: drop one entry, closing the gap, or append at the tail
    if (rm_en) begin
      for (int k = 0; k < MAX_CLIENTS - 1; k++) begin
        if (SLOT_W'(k) >= rm_pos) begin
          wq_slot[k] <= wq_slot[k+1];
          wq_res[k]  <= wq_res[k+1];
        end
      end
    end else if (req_wait) begin
      wq_slot[wq_len[SLOT_W-1:0]] <= s_idx;
      wq_res[wq_len[SLOT_W-1:0]]  <= item.res;
    end
    if (busy_idle && item.op == OP_CREATE && !s_found && free_found)
      slot_client[free_idx] <= item.client_id;

    if (rst) begin
      state <= S_IDLE;
      box_x <= '0;
      box_y <= '0;
      wq_len <= '0;
      for (int b = 0; b < BOX_SLOTS; b++) box_count[b] <= 8'd0;
      for (int i = 0; i < MAX_CLIENTS; i++) begin
        slot_valid[i] <= 1'b0;
        held_len[i]   <= '0;
      end
    end else begin
      if (rm_en) wq_len <= wq_len - 1'b1;
      else if (req_wait) wq_len <= wq_len + 1'b1;

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            res <= '{kind: 1'b0, status: ST_OK, woken_client: 8'd0,
                     granted_resource: 3'd0, location: 15'd0, last: 1'b1};
            state <= S_EMIT;
            unique case (item.op)
              OP_CREATE: begin
                if (s_found) res.status <= ST_EXISTS;
                else if (!free_found) res.status <= ST_FULL;
                else begin
                  slot_valid[free_idx] <= 1'b1;
                  held_len[free_idx]   <= '0;
                end
              end
              OP_MOVE: begin
                if (!s_found) res.status <= ST_UNKNOWN;
              end
              OP_REQUEST: begin
                if (!s_found) res.status <= ST_UNKNOWN;
                else if (in_q) res.status <= ST_BLOCKED;
                else if (hl_rd >= HLEN_W'(MAX_HELD)) res.status <= ST_FULL;
                else if (bc_rd != 8'd0) begin
                  box_count[item.res] <= bc_rd - 8'd1;
                  held_len[s_idx]     <= hl_rd + 1'b1;
                end else res.status <= ST_BLOCKED;
              end
              OP_KILL: begin
                if (!s_found) res.status <= ST_UNKNOWN;
                else begin
                  kslot <= s_idx;
                  klen  <= hl_rd;
                  kidx  <= '0;
                  state <= S_KILL_RD;
                end
              end
              OP_LOCATE: res.location <= loc;
              default: ;
            endcase
          end
        end
        S_KILL_RD: begin
          if (kidx == klen) begin
            held_len[kslot]   <= '0;
            slot_valid[kslot] <= 1'b0;
            res <= '{kind: 1'b0, status: ST_OK, woken_client: 8'd0,
                     granted_resource: 3'd0, location: 15'd0, last: 1'b1};
            state <= S_EMIT;
          end else begin
            state <= S_KILL_PROC;
          end
        end
        S_KILL_PROC: begin
          if (w_found) begin
            if (wake_app) held_len[w_slot] <= hl_rd + 1'b1;
            res <= '{kind: 1'b1, status: ST_OK, woken_client: slot_client[w_slot],
                     granted_resource: hrdata, location: 15'd0, last: 1'b0};
            state <= S_EMIT;
          end else begin
            if (4'(hrdata) < 4'(NUM_BOXES) && bc_rd != 8'hFF)
              box_count[hrdata] <= bc_rd + 8'd1;
            kidx  <= kidx + 1'b1;
            state <= S_KILL_RD;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            if (res.last) state <= S_IDLE;
            else begin
              kidx  <= kidx + 1'b1;
              state <= S_KILL_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_we) begin
        case (cfg_index)
          CFG_COUNTS: begin
            for (int b = 0; b < BOX_SLOTS; b++) box_count[b] <= cfg_data[8*b +: 8];
          end
          CFG_XPOS: box_x <= cfg_data;
          CFG_YPOS: box_y <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* rtl/counted_resource_grant_manager_top.sv */
// Create, move, request and locate pass through the front queue, the executor's result
// register and the output register. Kill walks the client's held units one by one,
// handing each to the oldest waiter for its box, with a result per wake, or back to its box.
// The executor takes one request at a time; the front queue holds one more meanwhile.
// Kill's walk of the held-unit memory sets the worst case.
// Reset (rst, synchronous): clears box counts and positions, the client table,
// held lengths, the wait queue and both channels; no clearing pass is needed.
// ----------------------------------------------------------------------------
// counted_resource_grant_manager_top
// Counting semaphores per box with FIFO waiters, for a table of clients.
// ----------------------------------------------------------------------------
module counted_resource_grant_manager_top (
  input  logic                           clk,
  input  logic                           rst,
  crgm_req_if.sink                       req,
  crgm_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [crgm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);
  import crgm_pkg::*;

  // front to back: decoded request and its handshake
  item_t   item;
  logic    item_valid, item_ready;
  // back to output register
  result_t res;
  logic    res_valid, res_ready;

  // Front: accept and classify requests, hold up to two.
  crgm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready)
  );

  // Back: execute one request, emit its wakes and its final status.
  crgm_exec u_exec (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
  );

  // Output register: advance when empty or being drained, else hold.
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.kind             <= res.kind;
      rsp.status           <= res.status;
      rsp.woken_client     <= res.woken_client;
      rsp.granted_resource <= res.granted_resource;
      rsp.location         <= res.location;
      rsp.last             <= res.last;
    end
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

endmodule

/* rtl/crgm_checker.sv */
// ----------------------------------------------------------------------------
// crgm_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "counted_resource_grant_manager_top_macros.svh"

module crgm_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_kind,
  input logic [2:0]  rsp_status,
  input logic [7:0]  rsp_woken,
  input logic [2:0]  rsp_granted,
  input logic [14:0] rsp_location,
  input logic        rsp_last
);
  import crgm_pkg::*;

  `CRGM_ASSERT(a_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_woken) && $stable(rsp_location) && $stable(rsp_last))
  `CRGM_ASSERT(a_wake, rsp_valid && rsp_kind |-> !rsp_last && rsp_status == ST_OK && rsp_location == 15'd0)
  `CRGM_ASSERT(a_final, rsp_valid && !rsp_kind |-> rsp_last && rsp_woken == 8'd0 && rsp_granted == 3'd0)
  `CRGM_ASSERT_ALWAYS(a_rst, $past(rst) |-> !rsp_valid)

endmodule

bind counted_resource_grant_manager_top crgm_checker u_crgm_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_kind     (rsp.kind),
  .rsp_status   (rsp.status),
  .rsp_woken    (rsp.woken_client),
  .rsp_granted  (rsp.granted_resource),
  .rsp_location (rsp.location),
  .rsp_last     (rsp.last)
);

/* tb/tb_counted_resource_grant_manager_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counted_resource_grant_manager_top
// Self-checking bench for the counted resource grant manager. A short table
// of directed requests covers the edge cases. Random client traffic follows,
// over several box settings. Results are checked against a local model of the
// box counts, client table, held lists and FIFO wait queue, or typed-in values.
// ----------------------------------------------------------------------------
module tb_counted_resource_grant_manager_top;
  import crgm_pkg::*;

  localparam logic [2:0] OP_UNDEF5 = 3'd5;
  localparam logic [2:0] OP_UNDEF6 = 3'd6;
  localparam int IDLE_LIMIT = 5000;   // cycles with no handshake on either side
  localparam int SETTLE     = 120;    // longest kill walk, with margin

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  crgm_req_if req_ch ();
  crgm_rsp_if rsp_ch ();

  counted_resource_grant_manager_top uut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // ---------------------------------------------------------------- model --
  logic [63:0] pos_x_reg, pos_y_reg;
  logic [7:0]  box_units [NUM_BOXES];
  logic        slot_used [MAX_CLIENTS];
  logic [7:0]  slot_id [MAX_CLIENTS];
  logic [2:0]  held_box [MAX_CLIENTS][MAX_HELD];
  int          held_cnt [MAX_CLIENTS];
  int          waiter_slot [$];
  logic [2:0]  waiter_box [$];

  result_t expected_results [$];
  int errors, n_requests, n_wakes, n_blocked;

  function automatic int lookup_client(input logic [7:0] id);
    for (int i = 0; i < MAX_CLIENTS; i++)
      if (slot_used[i] && slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int waiting_at(input int s);
    for (int k = 0; k < waiter_slot.size(); k++)
      if (waiter_slot[k] == s) return k;
    return -1;
  endfunction

  function automatic result_t make_result(input logic kind, input status_t st,
                                          input logic [7:0] who, input logic [2:0] box,
                                          input logic [14:0] loc, input logic lst);
    result_t r;
    r.kind = kind; r.status = st; r.woken_client = who;
    r.granted_resource = box; r.location = loc; r.last = lst;
    return r;
  endfunction

  // Advance the model by one request and queue the results it owes.
  task automatic predict_grants(input logic [2:0] op, input logic [7:0] id,
                                input logic [2:0] res_in, input logic [7:0] px,
                                input logic [7:0] py);
    int s, q, w, i;
    logic [2:0] r, hb;
    logic given;
    status_t st;
    logic [14:0] loc;
    s = lookup_client(id);
    r = res_in % NUM_BOXES;
    st = ST_OK;
    loc = '0;
    case (op)
      OP_CREATE: begin
        if (s >= 0) st = ST_EXISTS;
        else begin
          for (i = 0; i < MAX_CLIENTS && slot_used[i]; i++) ;
          if (i >= MAX_CLIENTS) st = ST_FULL;
          else begin
            slot_used[i] = 1'b1; slot_id[i] = id; held_cnt[i] = 0;
          end
        end
      end
      OP_MOVE: if (s < 0) st = ST_UNKNOWN;
      OP_REQUEST: begin
        if (s < 0) st = ST_UNKNOWN;
        else if (waiting_at(s) >= 0) st = ST_BLOCKED;
        else if (held_cnt[s] >= MAX_HELD) st = ST_FULL;
        else if (box_units[r] > 0) begin
          box_units[r]--;
          held_box[s][held_cnt[s]] = r;
          held_cnt[s]++;
        end else begin
          if (waiter_slot.size() < MAX_CLIENTS) begin
            waiter_slot.push_back(s); waiter_box.push_back(r);
          end
          st = ST_BLOCKED;
        end
      end
      OP_KILL: begin
        if (s < 0) st = ST_UNKNOWN;
        else begin
          // drop the client from the wait queue, then hand back its units in order
          q = waiting_at(s);
          if (q >= 0) begin
            waiter_slot.delete(q); waiter_box.delete(q);
          end
          for (i = 0; i < held_cnt[s]; i++) begin
            hb = held_box[s][i];
            given = 1'b0;
            for (int k = 0; k < waiter_slot.size(); k++) begin
              if (waiter_box[k] == hb) begin
                w = waiter_slot[k];
                waiter_slot.delete(k); waiter_box.delete(k);
                if (held_cnt[w] < MAX_HELD) begin
                  held_box[w][held_cnt[w]] = hb;
                  held_cnt[w]++;
                end
                expected_results.push_back(make_result(1'b1, ST_OK, slot_id[w], hb, '0, 1'b0));
                given = 1'b1;
                break;
              end
            end
            if (!given && box_units[hb] < 8'd255) box_units[hb]++;
          end
          held_cnt[s] = 0;
          slot_used[s] = 1'b0;
        end
      end
      OP_LOCATE: loc = 15'(pos_x_reg[r*8 +: 8]) * 15'(POS_SCALE) + 15'(pos_y_reg[r*8 +: 8]);
      default: ;
    endcase
    expected_results.push_back(make_result(1'b0, st, '0, '0, loc, 1'b1));
  endtask

  // ------------------------------------------------------------- drivers --
  // Write one register with a one-cycle enable strobe, then drop the enable before returning.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COUNTS) for (int b = 0; b < NUM_BOXES; b++) box_units[b] = val[b*8 +: 8];
    else if (idx == CFG_XPOS) pos_x_reg = val;
    else if (idx == CFG_YPOS) pos_y_reg = val;
    @(posedge clk);
  endtask

  // Hold until every expected result is in, then let a kill walk finish.
  task automatic drain;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int pick_gap;
    int d;
    d = $urandom_range(0, 99);
    if (d < 55) return 0;
    if (d < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one request, hold it until accepted, then maybe idle.
  task automatic send_request(input logic [2:0] op, input logic [7:0] id,
                              input logic [2:0] res, input logic [7:0] px,
                              input logic [7:0] py, input logic typed,
                              input status_t typed_st, input logic [14:0] typed_loc);
    int gap;
    req_ch.valid <= 1'b1;
    req_ch.operation <= op; req_ch.client_id <= id; req_ch.resource <= res;
    req_ch.pos_x <= px; req_ch.pos_y <= py;
    do @(posedge clk); while (!req_ch.ready);
    predict_grants(op, id, res, px, py);
    // typed-in rows replace the model's final answer with the hand-written one
    if (typed) begin
      expected_results[expected_results.size()-1].status = typed_st;
      expected_results[expected_results.size()-1].location = typed_loc;
    end
    n_requests++;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_sender;
    req_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random client traffic over a small pool of ids so clients meet again.
  task automatic random_traffic(input int count);
    logic [7:0] ids [10] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80,
                              8'h3C, 8'hC3, 8'h7E, 8'h42};
    logic [2:0] op;
    logic [7:0] id;
    int d;
    for (int n = 0; n < count; n++) begin
      d = $urandom_range(0, 99);
      if (d < 20) op = OP_CREATE;
      else if (d < 28) op = OP_MOVE;
      else if (d < 60) op = OP_REQUEST;
      else if (d < 78) op = OP_KILL;
      else if (d < 90) op = OP_LOCATE;
      else op = 3'($urandom_range(5, 7));
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : ids[$urandom_range(0, 9)];
      send_request(op, id, 3'($urandom), 8'($urandom), 8'($urandom), 1'b0, ST_OK, '0);
    end
  endtask

  // ----------------------------------------------------- directed table --
  typedef struct {
    logic [2:0]  op;
    logic [7:0]  id;
    logic [2:0]  res;
    logic [7:0]  px;
    logic [7:0]  py;
    logic        typed;
    status_t     st;
    logic [14:0] loc;
  } row_t;

  // Boxes 0 and 1 start with one unit each; box 7 sits at the far corner.
  row_t directed [18] = '{
    '{OP_CREATE,  8'h00, 3'd0, 8'h00, 8'h00, 1'b1, ST_OK,      15'd0},
    '{OP_CREATE,  8'hFF, 3'd0, 8'hFF, 8'hFF, 1'b1, ST_OK,      15'd0},
    '{OP_CREATE,  8'h00, 3'd0, 8'h00, 8'h00, 1'b1, ST_EXISTS,  15'd0},
    '{OP_MOVE,    8'h5A, 3'd0, 8'h12, 8'h34, 1'b1, ST_UNKNOWN, 15'd0},
    '{OP_MOVE,    8'hFF, 3'd0, 8'h12, 8'h34, 1'b1, ST_OK,      15'd0},
    '{OP_REQUEST, 8'h00, 3'd0, 8'h00, 8'h00, 1'b1, ST_OK,      15'd0},
    '{OP_REQUEST, 8'hFF, 3'd0, 8'h00, 8'h00, 1'b1, ST_BLOCKED, 15'd0},
    '{OP_REQUEST, 8'hFF, 3'd1, 8'h00, 8'h00, 1'b1, ST_BLOCKED, 15'd0},
    '{OP_REQUEST, 8'h33, 3'd1, 8'h00, 8'h00, 1'b1, ST_UNKNOWN, 15'd0},
    '{OP_LOCATE,  8'h00, 3'd7, 8'h00, 8'h00, 1'b1, ST_OK,      15'd25755},
    '{OP_LOCATE,  8'h99, 3'd0, 8'h00, 8'h00, 1'b1, ST_OK,      15'd0},
    '{OP_UNDEF5,  8'h00, 3'd0, 8'h00, 8'h00, 1'b1, ST_OK,      15'd0},
    '{OP_UNDEF6,  8'hFF, 3'd7, 8'hFF, 8'hFF, 1'b1, ST_OK,      15'd0},
    '{OP_NOP,     8'h00, 3'd0, 8'h00, 8'h00, 1'b1, ST_OK,      15'd0},
    '{OP_KILL,    8'h00, 3'd0, 8'h00, 8'h00, 1'b0, ST_OK,      15'd0},
    '{OP_KILL,    8'h77, 3'd0, 8'h00, 8'h00, 1'b1, ST_UNKNOWN, 15'd0},
    '{OP_REQUEST, 8'hFF, 3'd1, 8'h00, 8'h00, 1'b0, ST_OK,      15'd0},
    '{OP_KILL,    8'hFF, 3'd0, 8'h00, 8'h00, 1'b0, ST_OK,      15'd0}
  };

  // ------------------------------------------------------ result checker --
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      // mostly short stalls, sometimes a long one, often none at all
      if ($urandom_range(0, 99) < 25)
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0d status %0d", $time,
                 rsp_ch.kind, rsp_ch.status);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.kind !== want.kind || rsp_ch.status !== want.status ||
            rsp_ch.woken_client !== want.woken_client ||
            rsp_ch.granted_resource !== want.granted_resource ||
            rsp_ch.location !== want.location || rsp_ch.last !== want.last) begin
          $display("%0t: expected kind %0d st %0d woken %h box %0d loc %0d last %0d",
                   $time, want.kind, want.status, want.woken_client,
                   want.granted_resource, want.location, want.last);
          $display("%0t:   actual kind %0d st %0d woken %h box %0d loc %0d last %0d",
                   $time, rsp_ch.kind, rsp_ch.status, rsp_ch.woken_client,
                   rsp_ch.granted_resource, rsp_ch.location, rsp_ch.last);
          errors++;
        end
        if (want.kind) n_wakes++;
        if (!want.kind && want.status == ST_BLOCKED) n_blocked++;
      end
    end
  end

  // Watchdog: count cycles without any handshake.
  int quiet;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet <= 0;
    else if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // ------------------------------------------------------------ sequence --
  initial begin
    rst = 1'b1;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    req_ch.valid <= 1'b0; req_ch.operation <= '0; req_ch.client_id <= '0;
    req_ch.resource <= '0; req_ch.pos_x <= '0; req_ch.pos_y <= '0;
    errors = 0; n_requests = 0; n_wakes = 0; n_blocked = 0;
    pos_x_reg = '0; pos_y_reg = '0;
    for (int b = 0; b < NUM_BOXES; b++) box_units[b] = '0;
    for (int i = 0; i < MAX_CLIENTS; i++) begin
      slot_used[i] = 1'b0; held_cnt[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Phase A: scarce units, box 7 at the far corner.
    write_reg(CFG_COUNTS, 64'h0000_0000_0000_0101);
    write_reg(CFG_XPOS, 64'hFF00_0000_0000_0000);
    write_reg(CFG_YPOS, 64'hFF00_0000_0000_0000);
    foreach (directed[i])
      send_request(directed[i].op, directed[i].id, directed[i].res, directed[i].px,
                   directed[i].py, directed[i].typed, directed[i].st, directed[i].loc);

    // Fill the client table, then one create too many.
    for (int i = 0; i <= MAX_CLIENTS; i++)
      send_request(OP_CREATE, 8'(8'h10 + i), '0, 8'($urandom), 8'($urandom), 1'b0, ST_OK, '0);
    idle_sender();
    drain();

    // Phase B: full boxes. Fill one held list past its limit, reload the
    // counts while the units are held, and release them into full boxes.
    write_reg(CFG_COUNTS, '1);
    for (int i = 0; i <= MAX_HELD; i++)
      send_request(OP_REQUEST, 8'h10, 3'(i), '0, '0, 1'b0, ST_OK, '0);
    idle_sender();
    drain();
    write_reg(CFG_COUNTS, '1);
    for (int i = 0; i < MAX_CLIENTS; i++)
      send_request(OP_KILL, 8'(8'h10 + i), '0, '0, '0, 1'b0, ST_OK, '0);
    idle_sender();
    drain();

    // Phase C: random positions, one or two units per box.
    write_reg(CFG_XPOS, {$urandom, $urandom});
    write_reg(CFG_YPOS, {$urandom, $urandom});
    write_reg(CFG_COUNTS, 64'h0102_0101_0201_0102);
    random_traffic(35);
    idle_sender();
    drain();

    // Phase D: one unit each in boxes 1 and 4, so waiters pile up and kills hand over.
    write_reg(CFG_XPOS, '0);
    write_reg(CFG_COUNTS, 64'h0000_0001_0000_0100);
    random_traffic(35);
    idle_sender();
    drain();

    $display("Sent %0d requests over four box settings; saw %0d wake grants, %0d blocked.",
             n_requests, n_wakes, n_blocked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
